// ===== rtl/mtwq_pkg.sv =====
// ---------------------------------------------------------------------------
// mtwq_pkg
// Shared types and constants for the mutex table with wait queues.
// ---------------------------------------------------------------------------
package mtwq_pkg;

  localparam int KEY_W = 8;
  localparam int PID_W = 6;

  localparam int NUM_LOCKS_DEF   = 256;
  localparam int MAX_PROCS_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 8;

  typedef enum logic [2:0] {
    KIND_CREATE  = 3'd0,
    KIND_DESTROY = 3'd1,
    KIND_LOCK    = 3'd2,
    KIND_UNLOCK  = 3'd3,
    KIND_EXIT    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_QUEUED  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

endpackage

// ===== rtl/mutex_table_with_wait_queues.sv =====
// ---------------------------------------------------------------------------
// mutex_table_with_wait_queues
// Mutex table with per-key FIFO wait queues, one result per request.
// ---------------------------------------------------------------------------
// One request at a time. Lock, and unlock with an empty queue, go through
// accept, key read, update, and the load of the output register. Destroy
// and unlock with waiters walk the key's wait queue through the slot memory
// one waiter at a time, with a read and a write step per waiter and a final
// step to finish. Create scans the created bits one key per cycle. Exit reads
// the key entries from key 1 upward (a read and a check step per key), walks
// the queue of each key it frees, and then, if it waits in a queue, compacts
// that queue. No clearing pass follows reset.
module mutex_table_with_wait_queues #(
  parameter int NUM_LOCKS   = mtwq_pkg::NUM_LOCKS_DEF,
  parameter int MAX_PROCS   = mtwq_pkg::MAX_PROCS_DEF,
  parameter int QUEUE_DEPTH = mtwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                kind_i,
  input  logic [mtwq_pkg::KEY_W-1:0] key_i,
  input  logic [mtwq_pkg::PID_W-1:0] pid_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [mtwq_pkg::KEY_W-1:0] new_key_o,
  output logic                      woken_valid_o,
  output logic [mtwq_pkg::PID_W-1:0] woken_pid_o
);

  localparam int KW  = $clog2(NUM_LOCKS);
  localparam int PW  = $clog2(MAX_PROCS);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SAW = $clog2(NUM_LOCKS * QUEUE_DEPTH);
  localparam int NS  = NUM_LOCKS * QUEUE_DEPTH;

  typedef struct packed {
    logic                       own_v;
    logic [mtwq_pkg::PID_W-1:0] own_pid;
    logic                       cre_v;
    logic [mtwq_pkg::PID_W-1:0] cre_pid;
    logic [CW-1:0]              cnt;
  } ent_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_RD    = 12'h002,
    S_EXEC  = 12'h004,
    S_CSCAN = 12'h008,
    S_QRD   = 12'h010,
    S_QWR   = 12'h020,
    S_QEND  = 12'h040,
    S_XRD   = 12'h080,
    S_XCHK  = 12'h100,
    S_XWRD  = 12'h200,
    S_XWCHK = 12'h400,
    S_RESP  = 12'h800
  } state_e;

  typedef enum logic [1:0] {
    MODE_DROP    = 2'd0,
    MODE_COMPACT = 2'd1,
    MODE_UNLK    = 2'd2
  } mode_e;

  ent_t                        key_mem [NUM_LOCKS];
  logic [mtwq_pkg::PID_W-1:0]  slot_mem [NS];
  logic [KW-1:0]               pw_mem [MAX_PROCS];

  state_e state_d, state_q;
  mode_e  mode_d, mode_q;
  logic [2:0]                 kind_q;
  logic [mtwq_pkg::KEY_W-1:0] key_q;
  logic [mtwq_pkg::PID_W-1:0] pid_q;
  logic [KW-1:0]              k_d, k_q;
  ent_t                       ent_d, ent_q;
  logic [CW-1:0]              i_d, i_q, j_d, j_q;
  logic [mtwq_pkg::PID_W-1:0] tgt_d, tgt_q;
  logic                       exit_d, exit_q;
  logic [1:0]                 res_st_d, res_st_q;
  logic [mtwq_pkg::KEY_W-1:0] res_nk_d, res_nk_q;
  logic                       res_wv_d, res_wv_q;
  logic [mtwq_pkg::PID_W-1:0] res_wp_d, res_wp_q;
  logic [NUM_LOCKS-1:0]       created_d, created_q;
  logic [MAX_PROCS-1:0]       pwv_d, pwv_q;

  logic [KW-1:0]              kr_addr, kw_addr;
  logic                       kwe;
  ent_t                       kw_data, krd_q;
  logic [SAW-1:0]             sr_addr, sw_addr;
  logic                       swe;
  logic [mtwq_pkg::PID_W-1:0] sw_data, srd_q;
  logic                       pwe;
  logic [KW-1:0]              pw_data, pwrd_q;
  logic [PW-1:0]              pid_idx;

  logic out_valid_q;
  logic out_load;

  logic pid_ok, key_ok;
  ent_t ent_rd;

  function automatic logic [SAW-1:0] slot_addr(input logic [KW-1:0] k, input logic [CW-1:0] i);
    slot_addr = SAW'(k) * SAW'(QUEUE_DEPTH) + SAW'(i);
  endfunction

  assign pid_idx = PW'(pid_q);
  assign ent_rd  = krd_q;
  assign pid_ok  = 9'(pid_q) < 9'(MAX_PROCS);
  assign key_ok  = (key_q != '0) && (9'(key_q) < 9'(NUM_LOCKS)) && created_q[KW'(key_q)];

  always_ff @(posedge clk_i) begin
    if (kwe) begin
      key_mem[kw_addr] <= kw_data;
    end
    krd_q <= key_mem[kr_addr];
    if (swe) begin
      slot_mem[sw_addr] <= sw_data;
    end
    srd_q <= slot_mem[sr_addr];
    if (pwe) begin
      pw_mem[pid_idx] <= pw_data;
    end
    pwrd_q <= pw_mem[pid_idx];
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    k_d       = k_q;
    ent_d     = ent_q;
    i_d       = i_q;
    j_d       = j_q;
    tgt_d     = tgt_q;
    exit_d    = exit_q;
    res_st_d  = res_st_q;
    res_nk_d  = res_nk_q;
    res_wv_d  = res_wv_q;
    res_wp_d  = res_wp_q;
    created_d = created_q;
    pwv_d     = pwv_q;
    kr_addr   = KW'(key_q);
    kwe       = 1'b0;
    kw_addr   = k_q;
    kw_data   = ent_q;
    sr_addr   = slot_addr(k_q, i_q);
    swe       = 1'b0;
    sw_addr   = slot_addr(k_q, j_q);
    sw_data   = srd_q;
    pwe       = 1'b0;
    pw_data   = k_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        res_st_d = mtwq_pkg::ST_REFUSED;
        res_nk_d = '0;
        res_wv_d = 1'b0;
        res_wp_d = '0;
        exit_d   = 1'b0;
        i_d      = '0;
        j_d      = '0;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        k_d     = KW'(key_q);
        ent_d   = ent_rd;
        state_d = S_RESP;
        if (pid_ok) begin
          case (kind_q)
            mtwq_pkg::KIND_CREATE: begin
              k_d     = KW'(1);
              state_d = S_CSCAN;
            end
            mtwq_pkg::KIND_DESTROY: begin
              if (key_ok) begin
                mode_d  = MODE_DROP;
                state_d = S_QRD;
              end
            end
            mtwq_pkg::KIND_LOCK: begin
              if (key_ok && !pwv_q[pid_idx]) begin
                kwe     = 1'b1;
                kw_addr = KW'(key_q);
                kw_data = ent_rd;
                if (!ent_rd.own_v) begin
                  kw_data.own_v   = 1'b1;
                  kw_data.own_pid = pid_q;
                  res_st_d        = mtwq_pkg::ST_OK;
                end else if (ent_rd.cnt >= CW'(QUEUE_DEPTH)) begin
                  kwe      = 1'b0;
                  res_st_d = mtwq_pkg::ST_FULL;
                end else begin
                  kw_data.cnt     = ent_rd.cnt + 1'b1;
                  swe             = 1'b1;
                  sw_addr         = slot_addr(KW'(key_q), ent_rd.cnt);
                  sw_data         = pid_q;
                  pwe             = 1'b1;
                  pw_data         = KW'(key_q);
                  pwv_d[pid_idx]  = 1'b1;
                  res_st_d        = mtwq_pkg::ST_QUEUED;
                end
              end
            end
            mtwq_pkg::KIND_UNLOCK: begin
              if (key_ok && ent_rd.own_v && ent_rd.own_pid == pid_q) begin
                if (ent_rd.cnt == '0) begin
                  kwe           = 1'b1;
                  kw_addr       = KW'(key_q);
                  kw_data       = ent_rd;
                  kw_data.own_v = 1'b0;
                  res_st_d      = mtwq_pkg::ST_OK;
                end else begin
                  mode_d  = MODE_UNLK;
                  state_d = S_QRD;
                end
              end
            end
            mtwq_pkg::KIND_EXIT: begin
              k_d     = KW'(1);
              exit_d  = 1'b1;
              state_d = S_XRD;
            end
            default: ;
          endcase
        end
      end
      S_CSCAN: begin
        if (!created_q[k_q]) begin
          created_d[k_q] = 1'b1;
          kwe            = 1'b1;
          kw_data        = '0;
          kw_data.cre_v  = 1'b1;
          kw_data.cre_pid = pid_q;
          res_st_d       = mtwq_pkg::ST_OK;
          res_nk_d       = mtwq_pkg::KEY_W'(k_q);
          state_d        = S_RESP;
        end else if (k_q == KW'(NUM_LOCKS - 1)) begin
          state_d = S_RESP;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_QRD: begin
        if (i_q == ent_q.cnt) begin
          state_d = S_QEND;
        end else begin
          state_d = S_QWR;
        end
      end
      S_QWR: begin
        i_d     = i_q + 1'b1;
        state_d = S_QRD;
        case (mode_q)
          MODE_DROP: begin
            if (9'(srd_q) < 9'(MAX_PROCS)) begin
              pwv_d[PW'(srd_q)] = 1'b0;
            end
          end
          MODE_UNLK: begin
            if (i_q == '0) begin
              tgt_d = srd_q;
            end else begin
              swe = 1'b1;
              j_d = j_q + 1'b1;
            end
          end
          default: begin
            if (srd_q != tgt_q) begin
              swe = 1'b1;
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end
      S_QEND: begin
        state_d = S_RESP;
        res_st_d = mtwq_pkg::ST_OK;
        case (mode_q)
          MODE_DROP: begin
            created_d[k_q] = 1'b0;
            if (exit_q) begin
              if (k_q == KW'(NUM_LOCKS - 1)) begin
                state_d = S_XWRD;
              end else begin
                k_d     = k_q + 1'b1;
                state_d = S_XRD;
              end
            end
          end
          MODE_UNLK: begin
            kwe             = 1'b1;
            kw_data.own_v   = 1'b1;
            kw_data.own_pid = tgt_q;
            kw_data.cnt     = j_q;
            pwv_d[PW'(tgt_q)] = 1'b0;
            res_wv_d        = 1'b1;
            res_wp_d        = tgt_q;
          end
          default: begin
            kwe            = 1'b1;
            kw_data.cnt    = j_q;
            pwv_d[pid_idx] = 1'b0;
          end
        endcase
      end
      S_XRD: begin
        kr_addr = k_q;
        state_d = S_XCHK;
      end
      S_XCHK: begin
        ent_d = ent_rd;
        i_d   = '0;
        if (created_q[k_q] && ent_rd.cre_v && ent_rd.cre_pid == pid_q) begin
          mode_d  = MODE_DROP;
          state_d = S_QRD;
        end else if (k_q == KW'(NUM_LOCKS - 1)) begin
          state_d = S_XWRD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_XRD;
        end
      end
      S_XWRD: begin
        kr_addr  = pwrd_q;
        res_st_d = mtwq_pkg::ST_OK;
        if (pwv_q[pid_idx]) begin
          state_d = S_XWCHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_XWCHK: begin
        ent_d   = ent_rd;
        k_d     = pwrd_q;
        i_d     = '0;
        j_d     = '0;
        tgt_d   = pid_q;
        mode_d  = MODE_COMPACT;
        state_d = S_QRD;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_DROP;
      exit_q      <= 1'b0;
      created_q   <= '0;
      pwv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      exit_q    <= exit_d;
      created_q <= created_d;
      pwv_q     <= pwv_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      pid_q  <= pid_i;
    end
    k_q      <= k_d;
    ent_q    <= ent_d;
    i_q      <= i_d;
    j_q      <= j_d;
    tgt_q    <= tgt_d;
    res_st_q <= res_st_d;
    res_nk_q <= res_nk_d;
    res_wv_q <= res_wv_d;
    res_wp_q <= res_wp_d;
    if (out_load) begin
      status_o      <= res_st_q;
      new_key_o     <= res_nk_q;
      woken_valid_o <= res_wv_q;
      woken_pid_o   <= res_wp_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mtwq_checker.sv =====
// ---------------------------------------------------------------------------
// mtwq_checker
// Port-level checks on the mutex table handshakes and results, bound to the top level.
// ---------------------------------------------------------------------------
module mtwq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [mtwq_pkg::KEY_W-1:0] new_key_o,
  input logic                       woken_valid_o,
  input logic [mtwq_pkg::PID_W-1:0] woken_pid_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(new_key_o) && $stable(woken_valid_o) && $stable(woken_pid_o))
    else $error("result changed while stalled");

  a_woken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && woken_valid_o |-> status_o == mtwq_pkg::ST_OK && new_key_o == '0)
    else $error("woken result with bad status or key");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mtwq_pkg::ST_OK |-> new_key_o == '0 && !woken_valid_o)
    else $error("failed request carries key or wake");

  a_no_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !woken_valid_o |-> woken_pid_o == '0)
    else $error("woken pid without wake");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

endmodule

bind mutex_table_with_wait_queues mtwq_checker u_mtwq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .new_key_o     (new_key_o),
  .woken_valid_o (woken_valid_o),
  .woken_pid_o   (woken_pid_o)
);
